### design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// shared result kinds, error codes, opcodes and the record type passed
// from the frame parser through the result queue to the output stage
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

    localparam int LEN_W = 63;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_RSV      = 3'd0;
    localparam logic [2:0] ERR_OPCODE   = 3'd1;
    localparam logic [2:0] ERR_LEN16    = 3'd2;
    localparam logic [2:0] ERR_LEN64    = 3'd3;
    localparam logic [2:0] ERR_MASKED   = 3'd4;
    localparam logic [2:0] ERR_CONTROL  = 3'd5;

    localparam logic [3:0] OP_CONT      = 4'd0;
    localparam logic [3:0] OP_TEXT      = 4'd1;
    localparam logic [3:0] OP_BINARY    = 4'd2;
    localparam logic [3:0] OP_CLOSE     = 4'd8;
    localparam logic [3:0] OP_PING      = 4'd9;
    localparam logic [3:0] OP_PONG      = 4'd10;

    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_MAX = 7'd125;

    // compact result record: value holds length, data byte or error code
    typedef struct packed {
        logic [1:0]       kind;
        logic             fin;
        logic [3:0]       opcode;
        logic [3:0]       hdr_len;
        logic             eof;
        logic [LEN_W-1:0] value;
    } rec_t;

endpackage

`default_nettype wire

### design/wsfd_front.sv
// ----------------------------------------------------------------------------
// wsfd_front
// frame parser: walks the header bytes, checks protocol rules, counts
// payload bytes and emits one compact record per result
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output wsfd_pkg::rec_t     rec,
    output logic               rec_valid
);

    typedef enum logic [2:0]
    {
        PH_FIRST,
        PH_SECOND,
        PH_EXT,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic                       fin_reg, fin_next;
    logic [3:0]                 opcode_reg, opcode_next;
    logic                       mask_reg, mask_next;
    logic [3:0]                 ext_left_reg, ext_left_next;
    logic [63:0]                acc_reg, acc_next;
    logic [wsfd_pkg::LEN_W-1:0] remain_reg, remain_next;
    logic [3:0]                 hdr_seen_reg, hdr_seen_next;

    logic                       accept;
    logic                       known;
    logic                       do_finish;
    logic [63:0]                fin_len;
    logic [63:0]                acc_shift;
    logic [wsfd_pkg::LEN_W-1:0] remain_dec;

    assign accept     = in_valid && !q_full;
    assign acc_shift  = {acc_reg[55:0], in_byte};
    assign remain_dec = remain_reg - wsfd_pkg::LEN_W'(1);

    always_comb
    begin
        unique case (in_byte[3:0]) inside
            wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY,
            wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG:
                known = 1'b1;
            default:
                known = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        mask_next     = mask_reg;
        ext_left_next = ext_left_reg;
        acc_next      = acc_reg;
        remain_next   = remain_reg;
        hdr_seen_next = hdr_seen_reg;
        rec           = '0;
        rec_valid     = 1'b0;
        do_finish     = 1'b0;
        fin_len       = acc_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HALT:
                begin
                end
                PH_SECOND:
                begin
                    hdr_seen_next = 4'd2;
                    mask_next     = in_byte[7];
                    if (in_byte[6:0] <= wsfd_pkg::LEN_CODE_MAX)
                    begin
                        acc_next  = {57'd0, in_byte[6:0]};
                        fin_len   = {57'd0, in_byte[6:0]};
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        acc_next      = '0;
                        ext_left_next = (in_byte[6:0] == wsfd_pkg::LEN_CODE_16) ? 4'd2 : 4'd8;
                        phase_next    = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    acc_next      = acc_shift;
                    hdr_seen_next = hdr_seen_reg + 4'd1;
                    ext_left_next = ext_left_reg - 4'd1;
                    fin_len       = acc_shift;
                    if (ext_left_next == 4'd0)
                    begin
                        if (hdr_seen_next == 4'd4)
                        begin
                            if (acc_shift <= 64'd125)
                            begin
                                rec_valid     = 1'b1;
                                rec.kind      = wsfd_pkg::KIND_ERROR;
                                rec.value[2:0] = wsfd_pkg::ERR_LEN16;
                                phase_next    = PH_HALT;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                        else if (acc_shift[63] || acc_shift[63:16] == 48'd0)
                        begin
                            rec_valid      = 1'b1;
                            rec.kind       = wsfd_pkg::KIND_ERROR;
                            rec.value[2:0] = wsfd_pkg::ERR_LEN64;
                            phase_next     = PH_HALT;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    rec_valid      = 1'b1;
                    rec.kind       = wsfd_pkg::KIND_PAYLOAD;
                    rec.value[7:0] = in_byte;
                    remain_next    = remain_dec;
                    if (remain_dec == '0)
                    begin
                        rec.eof    = 1'b1;
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    hdr_seen_next = 4'd1;
                    if (in_byte[6:4] != 3'd0)
                    begin
                        rec_valid      = 1'b1;
                        rec.kind       = wsfd_pkg::KIND_ERROR;
                        rec.value[2:0] = wsfd_pkg::ERR_RSV;
                        phase_next     = PH_HALT;
                    end
                    else if (!known)
                    begin
                        rec_valid      = 1'b1;
                        rec.kind       = wsfd_pkg::KIND_ERROR;
                        rec.value[2:0] = wsfd_pkg::ERR_OPCODE;
                        phase_next     = PH_HALT;
                    end
                    else
                    begin
                        fin_next    = in_byte[7];
                        opcode_next = in_byte[3:0];
                        phase_next  = PH_SECOND;
                    end
                end
            endcase

            // length complete: masked check, then control frame rule
            if (do_finish)
            begin
                rec_valid = 1'b1;
                if (mask_next)
                begin
                    rec.kind       = wsfd_pkg::KIND_ERROR;
                    rec.value[2:0] = wsfd_pkg::ERR_MASKED;
                    phase_next     = PH_HALT;
                end
                else if (opcode_reg[3] && (!fin_reg || fin_len > 64'd125))
                begin
                    rec.kind       = wsfd_pkg::KIND_ERROR;
                    rec.value[2:0] = wsfd_pkg::ERR_CONTROL;
                    phase_next     = PH_HALT;
                end
                else
                begin
                    rec.kind    = wsfd_pkg::KIND_HEADER;
                    rec.fin     = fin_reg;
                    rec.opcode  = opcode_reg;
                    rec.hdr_len = hdr_seen_next;
                    rec.value   = fin_len[wsfd_pkg::LEN_W-1:0];
                    if (fin_len == 64'd0)
                    begin
                        rec.eof    = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        remain_next = fin_len[wsfd_pkg::LEN_W-1:0];
                        phase_next  = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            fin_reg      <= 1'b0;
            opcode_reg   <= 4'd0;
            mask_reg     <= 1'b0;
            ext_left_reg <= 4'd0;
            acc_reg      <= '0;
            remain_reg   <= '0;
            hdr_seen_reg <= 4'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            mask_reg     <= mask_next;
            ext_left_reg <= ext_left_next;
            acc_reg      <= acc_next;
            remain_reg   <= remain_next;
            hdr_seen_reg <= hdr_seen_next;
        end
    end

endmodule

`default_nettype wire

### design/wsfd_queue.sv
// ----------------------------------------------------------------------------
// wsfd_queue
// small register queue of result records between parser and output stage
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire wsfd_pkg::rec_t wr_rec,
    input  wire logic           rd_en,
    output wsfd_pkg::rec_t      rd_rec,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsfd_pkg::rec_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_rec = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/wsfd_back.sv
// ----------------------------------------------------------------------------
// wsfd_back
// output stage: takes records from the queue, unpacks them into the result
// fields and holds the oldest result until it is popped
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire wsfd_pkg::rec_t             q_rec,
    input  wire logic                       q_empty,
    output logic                            q_rd,
    input  wire logic                       pop,
    output logic                            empty,
    output logic [1:0]                      kind,
    output logic                            fin_flag,
    output logic [3:0]                      frame_opcode,
    output logic [wsfd_pkg::LEN_W-1:0]      payload_length,
    output logic [3:0]                      header_length,
    output logic [7:0]                      payload_byte,
    output logic                            end_of_frame,
    output logic [2:0]                      error_code
);

    logic                       valid_reg;
    logic [1:0]                 kind_reg;
    logic                       fin_reg;
    logic [3:0]                 opcode_reg;
    logic [wsfd_pkg::LEN_W-1:0] len_reg;
    logic [3:0]                 hdr_len_reg;
    logic [7:0]                 data_reg;
    logic                       eof_reg;
    logic [2:0]                 err_reg;
    logic                       is_hdr;
    logic                       is_data;
    logic                       is_err;

    assign q_rd    = !q_empty && (!valid_reg || pop);
    assign is_hdr  = (q_rec.kind == wsfd_pkg::KIND_HEADER);
    assign is_data = (q_rec.kind == wsfd_pkg::KIND_PAYLOAD);
    assign is_err  = (q_rec.kind == wsfd_pkg::KIND_ERROR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            kind_reg    <= q_rec.kind;
            fin_reg     <= is_hdr && q_rec.fin;
            opcode_reg  <= is_hdr ? q_rec.opcode : 4'd0;
            len_reg     <= is_hdr ? q_rec.value : '0;
            hdr_len_reg <= is_hdr ? q_rec.hdr_len : 4'd0;
            data_reg    <= is_data ? q_rec.value[7:0] : 8'd0;
            eof_reg     <= !is_err && q_rec.eof;
            err_reg     <= is_err ? q_rec.value[2:0] : 3'd0;
        end
    end

    assign empty          = !valid_reg;
    assign kind           = kind_reg;
    assign fin_flag       = fin_reg;
    assign frame_opcode   = opcode_reg;
    assign payload_length = len_reg;
    assign header_length  = hdr_len_reg;
    assign payload_byte   = data_reg;
    assign end_of_frame   = eof_reg;
    assign error_code     = err_reg;

endmodule

`default_nettype wire

### design/websocket_frame_decoder.sv
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// receive-side frame header parser and payload pass-through for unmasked
// frames, one stream byte per transfer
// ----------------------------------------------------------------------------
// usage
//   input: rx_byte with push/full; a byte transfers on a clock edge with push
//   high and full low
//   output: result fields with empty/pop; the oldest result is shown while
//   empty is low and transfers on an edge with pop high
//   one byte per cycle sustained while full is low; a byte that makes a
//   result goes through the queue, then the output register, when drained
//   the parser writes records into a queue of QUEUE_DEPTH entries plus one
//   output register; when the receiver stalls the queue fills and full rises
//   once QUEUE_DEPTH records wait behind the output register
//   header bytes before the last one, and every byte after an error, make no
//   result; after an error the block stays silent until reset
//   reset clears the parser to expect the first header byte and empties the
//   queue and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 rx_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [1:0]                      kind,
    output logic                            fin_flag,
    output logic [3:0]                      frame_opcode,
    output logic [wsfd_pkg::LEN_W-1:0]      payload_length,
    output logic [3:0]                      header_length,
    output logic [7:0]                      payload_byte,
    output logic                            end_of_frame,
    output logic [2:0]                      error_code
);

    wsfd_pkg::rec_t front_rec;
    wsfd_pkg::rec_t q_rec;
    logic           front_valid;
    logic           q_full;
    logic           q_empty;
    logic           q_rd;

    assign full = q_full;

    wsfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_byte   (rx_byte),
        .q_full    (q_full),
        .rec       (front_rec),
        .rec_valid (front_valid)
    );

    wsfd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_valid),
        .wr_rec (front_rec),
        .rd_en  (q_rd),
        .rd_rec (q_rec),
        .full   (q_full),
        .empty  (q_empty)
    );

    wsfd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_rec          (q_rec),
        .q_empty        (q_empty),
        .q_rd           (q_rd),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .fin_flag       (fin_flag),
        .frame_opcode   (frame_opcode),
        .payload_length (payload_length),
        .header_length  (header_length),
        .payload_byte   (payload_byte),
        .end_of_frame   (end_of_frame),
        .error_code     (error_code)
    );

endmodule

`default_nettype wire

### design/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// port-level checks on the decoder's result channel
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_checker
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       empty,
    input  wire logic                       pop,
    input  wire logic [1:0]                 kind,
    input  wire logic [wsfd_pkg::LEN_W-1:0] payload_length,
    input  wire logic [3:0]                 header_length,
    input  wire logic [7:0]                 payload_byte,
    input  wire logic                       end_of_frame,
    input  wire logic [2:0]                 error_code
);

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(payload_byte)))
        else $error("result changed while stalled");

    // an error is the last result ever produced
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && kind == wsfd_pkg::KIND_ERROR) |=> empty)
        else $error("result after protocol error");

    // empty frame header carries a zero length
    a_eof_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == wsfd_pkg::KIND_HEADER && end_of_frame) |-> payload_length == '0)
        else $error("end of frame on header with payload");

    // header length is one of the three legal sizes
    a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == wsfd_pkg::KIND_HEADER) |->
        (header_length == 4'd2 || header_length == 4'd4 || header_length == 4'd10))
        else $error("bad header length");

    // errors never mark end of frame and carry a defined code
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == wsfd_pkg::KIND_ERROR) |-> (!end_of_frame && error_code <= 3'd5))
        else $error("bad error result fields");

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .kind           (kind),
    .payload_length (payload_length),
    .header_length  (header_length),
    .payload_byte   (payload_byte),
    .end_of_frame   (end_of_frame),
    .error_code     (error_code)
);

`default_nettype wire

### tb/ws_tb_pkg.sv
// ----------------------------------------------------------------------------
// ws_tb_pkg
// result record and frame decode tracker for the websocket frame decoder
// bench: every transferred byte runs through a parser of its own, and the
// results it produces wait in order until the output side delivers them
// ----------------------------------------------------------------------------
package ws_tb_pkg;

    import wsfd_pkg::*;

    typedef enum logic [1:0] {ST_FIRST, ST_SECOND, ST_EXT, ST_BODY} parse_state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             fin;
        logic [3:0]       opcode;
        logic [LEN_W-1:0] length;
        logic [3:0]       hdr_len;
        logic [7:0]       data;
        logic             eof;
        logic [2:0]       err;
    } frame_result_t;

    class frame_decode_model;
        frame_result_t    expected_results[$];
        int unsigned      failures;
        parse_state_t     state;
        logic             fin_hold;
        logic [3:0]       op_hold;
        logic             mask_hold;
        logic [3:0]       ext_left;
        logic [63:0]      len_acc;
        logic [LEN_W-1:0] body_left;
        logic [3:0]       hdr_count;
        logic             stopped;

        function new();
            failures  = 0;
            state     = ST_FIRST;
            fin_hold  = 1'b0;
            op_hold   = '0;
            mask_hold = 1'b0;
            ext_left  = '0;
            len_acc   = '0;
            body_left = '0;
            hdr_count = '0;
            stopped   = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void stop_with(input logic [2:0] code);
            frame_result_t r;
            r        = '0;
            r.kind   = KIND_ERROR;
            r.err    = code;
            stopped  = 1'b1;
            expected_results.push_back(r);
        endfunction

        // length is complete: masked and control rules, then the header
        function void header_done();
            frame_result_t r;
            if (mask_hold)
            begin
                stop_with(ERR_MASKED);
            end
            else if ((op_hold == OP_CLOSE || op_hold == OP_PING || op_hold == OP_PONG) &&
                     (!fin_hold || len_acc > LEN_CODE_MAX))
            begin
                stop_with(ERR_CONTROL);
            end
            else
            begin
                r         = '0;
                r.kind    = KIND_HEADER;
                r.fin     = fin_hold;
                r.opcode  = op_hold;
                r.length  = len_acc[LEN_W-1:0];
                r.hdr_len = hdr_count;
                if (len_acc == 64'd0)
                begin
                    r.eof = 1'b1;
                    state = ST_FIRST;
                end
                else
                begin
                    body_left = len_acc[LEN_W-1:0];
                    state     = ST_BODY;
                end
                expected_results.push_back(r);
            end
        endfunction

        function void take_byte(input logic [7:0] b);
            frame_result_t r;
            if (!stopped)
            begin
                case (state)
                    ST_SECOND:
                    begin
                        hdr_count = 4'd2;
                        mask_hold = b[7];
                        if (b[6:0] <= LEN_CODE_MAX)
                        begin
                            len_acc = {57'd0, b[6:0]};
                            header_done();
                        end
                        else
                        begin
                            len_acc  = '0;
                            ext_left = (b[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
                            state    = ST_EXT;
                        end
                    end
                    ST_EXT:
                    begin
                        len_acc   = {len_acc[55:0], b};
                        hdr_count = hdr_count + 4'd1;
                        ext_left  = ext_left - 4'd1;
                        if (ext_left == 4'd0)
                        begin
                            if (hdr_count == 4'd4)
                            begin
                                if (len_acc <= LEN_CODE_MAX)
                                    stop_with(ERR_LEN16);
                                else
                                    header_done();
                            end
                            else if (len_acc[63] || len_acc <= 64'hffff)
                                stop_with(ERR_LEN64);
                            else
                                header_done();
                        end
                    end
                    ST_BODY:
                    begin
                        r         = '0;
                        r.kind    = KIND_PAYLOAD;
                        r.data    = b;
                        body_left = body_left - LEN_W'(1);
                        if (body_left == '0)
                        begin
                            r.eof = 1'b1;
                            state = ST_FIRST;
                        end
                        expected_results.push_back(r);
                    end
                    default:
                    begin
                        hdr_count = 4'd1;
                        if (b[6:4] != 3'b000)
                            stop_with(ERR_RSV);
                        else if (!(b[3:0] == OP_CONT || b[3:0] == OP_TEXT ||
                                   b[3:0] == OP_BINARY || b[3:0] == OP_CLOSE ||
                                   b[3:0] == OP_PING || b[3:0] == OP_PONG))
                            stop_with(ERR_OPCODE);
                        else
                        begin
                            fin_hold = b[7];
                            op_hold  = b[3:0];
                            state    = ST_SECOND;
                        end
                    end
                endcase
            end
        endfunction

        function string describe(input frame_result_t r);
            return $sformatf("kind %0d fin %0d op %0d len %0h hlen %0d byte %02h eof %0d err %0d",
                             r.kind, r.fin, r.opcode, r.length, r.hdr_len, r.data, r.eof,
                             r.err);
        endfunction

        function void match_result(input frame_result_t got);
            frame_result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: %s", describe(got));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("result mismatch, expected: %s", describe(want));
                        $display("                 actual:   %s", describe(got));
                    end
                end
            end
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// bench for websocket_frame_decoder: well-formed frames of every opcode in the
// 7-bit and 16-bit length forms with random payload, under phases of sender gaps and receiver
// stalls, one long output stall and drain pauses; the run closes with one
// random protocol error or an open-ended huge frame, since errors are sticky
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wsfd_pkg::*;
    import ws_tb_pkg::*;

    typedef enum logic [1:0] {FORM_7, FORM_16, FORM_64} len_form_t;

    localparam logic [6:0] LEN_CODE_64    = 7'd127;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             push    = 1'b0;
    logic [7:0]       rx_byte = 8'd0;
    logic             pop     = 1'b0;
    logic             full;
    logic             empty;
    logic [1:0]       kind;
    logic             fin_flag;
    logic [3:0]       frame_opcode;
    logic [LEN_W-1:0] payload_length;
    logic [3:0]       header_length;
    logic [7:0]       payload_byte;
    logic             end_of_frame;
    logic [2:0]       error_code;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned bytes_sent     = 0;

    frame_decode_model decode_model;

    websocket_frame_decoder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .fin_flag       (fin_flag),
        .frame_opcode   (frame_opcode),
        .payload_length (payload_length),
        .header_length  (header_length),
        .payload_byte   (payload_byte),
        .end_of_frame   (end_of_frame),
        .error_code     (error_code)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [3:0] pick_data_op();
        case ($urandom_range(2))
            0:       return OP_CONT;
            1:       return OP_TEXT;
            default: return OP_BINARY;
        endcase
    endfunction

    function automatic logic [3:0] pick_control_op();
        case ($urandom_range(2))
            0:       return OP_CLOSE;
            1:       return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_model.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] first, input logic masked,
                               input len_form_t form, input logic [63:0] len);
        send_byte(first);
        case (form)
            FORM_7:
                send_byte({masked, len[6:0]});
            FORM_16:
            begin
                send_byte({masked, LEN_CODE_16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({masked, LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
    endtask

    task automatic send_body(input int unsigned n);
        repeat (n)
            send_byte(8'($urandom_range(255)));
    endtask

    // minimal length form, random payload
    task automatic send_frame(input logic fin, input logic [3:0] op, input int unsigned len);
        len_form_t form;
        if (len <= LEN_CODE_MAX)
            form = FORM_7;
        else if (len <= 65535)
            form = FORM_16;
        else
            form = FORM_64;
        send_header({fin, 3'b000, op}, 1'b0, form, 64'(len));
        send_body(len);
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic        fin;
        int unsigned len;
        int unsigned pick;
        if ($urandom_range(99) < 25)
        begin
            op  = pick_control_op();
            fin = 1'b1;
            case ($urandom_range(3))
                0:       len = 0;
                1:       len = 125;
                default: len = $urandom_range(20);
            endcase
        end
        else
        begin
            op   = pick_data_op();
            fin  = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 15)
                len = 0;
            else if (pick < 70)
                len = $urandom_range(16, 1);
            else if (pick < 85)
                len = $urandom_range(125, 17);
            else if (pick < 92)
                len = 126;
            else
                len = $urandom_range(300, 127);
        end
        send_frame(fin, op, len);
    endtask

    // errors are sticky until reset, so only one terminal case fits in a run
    task automatic send_closing_case();
        logic [63:0] len;
        logic [3:0]  op;
        logic        fin;
        fin = 1'($urandom_range(1));
        case ($urandom_range(6))
            0:
                send_byte({fin, 3'($urandom_range(7, 1)), 4'($urandom_range(15))});
            1:
            begin
                op = 4'($urandom_range(9));
                op = (op < 4'd5) ? op + 4'd3 : op + 4'd6;
                send_byte({fin, 3'b000, op});
            end
            2:
                send_header({fin, 3'b000, pick_data_op()}, 1'($urandom_range(1)), FORM_16,
                            64'($urandom_range(125)));
            3:
            begin
                len = {$urandom, $urandom};
                if ($urandom_range(1))
                    len[63] = 1'b1;
                else
                    len = 64'($urandom_range(65535));
                send_header({fin, 3'b000, pick_data_op()}, 1'($urandom_range(1)), FORM_64,
                            len);
            end
            4:
            begin
                op = $urandom_range(1) ? pick_control_op() : pick_data_op();
                if ($urandom_range(1))
                    send_header({fin, 3'b000, op}, 1'b1, FORM_7, 64'($urandom_range(125)));
                else
                    send_header({fin, 3'b000, op}, 1'b1, FORM_16,
                                64'($urandom_range(65535, 126)));
            end
            5:
            begin
                if ($urandom_range(1))
                    send_header({1'b0, 3'b000, pick_control_op()}, 1'b0, FORM_7,
                                64'($urandom_range(125)));
                else
                    send_header({1'b1, 3'b000, pick_control_op()}, 1'b0, FORM_16,
                                64'($urandom_range(65535, 126)));
            end
            default:
            begin
                len     = {$urandom, $urandom};
                len[63] = 1'b0;
                if ($urandom_range(1))
                    len = 64'h7fff_ffff_ffff_ffff;
                else if (len <= 64'hffff)
                    len[40] = 1'b1;
                send_header({fin, 3'b000, pick_data_op()}, 1'b0, FORM_64, len);
                send_body(6);
            end
        endcase
        send_body(8);
    endtask

    initial
    begin : stimulus
        int unsigned phase_end;
        decode_model = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every opcode, empty and short frames, extreme payload bytes
        send_frame(1'b1, OP_TEXT, 0);
        send_header({1'b0, 3'b000, OP_BINARY}, 1'b0, FORM_7, 64'd1);
        send_byte(8'h00);
        send_header({1'b0, 3'b000, OP_CONT}, 1'b0, FORM_7, 64'd2);
        send_byte(8'hff);
        send_byte(8'h80);
        send_frame(1'b1, OP_CONT, 0);
        send_frame(1'b1, OP_CLOSE, 0);
        send_header({1'b1, 3'b000, OP_PING}, 1'b0, FORM_7, 64'd1);
        send_byte(8'h7f);
        send_frame(1'b1, OP_PONG, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (ph == 0)
            begin
                // long output stall while bytes keep coming
                hold_request = 40;
                send_frame(1'b1, OP_BINARY, 100);
            end
            phase_end = bytes_sent + 280;
            while (bytes_sent < phase_end)
                send_random_frame();
            push <= 1'b0;
            do
                @(posedge clk);
            while (decode_model.pending() != 0);
        end

        send_closing_case();
        push <= 1'b0;
        do
            @(posedge clk);
        while (decode_model.pending() != 0);
        repeat (12) @(posedge clk);

        if (decode_model.failures == 0 && decode_model.pending() == 0)
            $display("PASS websocket_frame_decoder");
        else
            $display("FAIL websocket_frame_decoder");
        $finish;
    end

    initial
    begin : result_drain
        int unsigned   hold_left;
        frame_result_t got;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind    = kind;
                got.fin     = fin_flag;
                got.opcode  = frame_opcode;
                got.length  = payload_length;
                got.hdr_len = header_length;
                got.data    = payload_byte;
                got.eof     = end_of_frame;
                got.err     = error_code;
                decode_model.match_result(got);
            end
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stall_watch
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL websocket_frame_decoder");
        $finish;
    end

endmodule

### websocket_frame_decoder.f
design/wsfd_pkg.sv
design/wsfd_front.sv
design/wsfd_queue.sv
design/wsfd_back.sv
design/websocket_frame_decoder.sv
design/wsfd_checker.sv
tb/ws_tb_pkg.sv
tb/tb_top.sv
